@@ src/fspa_pkg.sv @@
// Shared constants, types and codes for the fixed segment pool allocator.
package fspa_pkg;

    // Pool geometry
    localparam int unsigned SEGMENTS      = 16;
    localparam int unsigned SEGMENT_WORDS = 256;

    // Field widths on the stream ports
    localparam int unsigned ADDR_W    = 12;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned CNT_OUT_W = 5;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 24;

    // Internal widths
    localparam int unsigned IDX_W  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int unsigned CNT_W  = $clog2(SEGMENTS + 1);
    localparam int unsigned WORD_W = $clog2(SEGMENT_WORDS + 1);
    localparam int unsigned BASE_W = ADDR_W + WORD_W;

    // Offset to index by reciprocal multiply: q = (addr * DIV_M) >> DIV_S,
    // exact for every ADDR_W-bit offset.
    localparam int unsigned DIV_L  = $clog2(SEGMENT_WORDS);
    localparam int unsigned DIV_S  = ADDR_W + DIV_L;
    localparam int unsigned DIV_M  = (2 ** DIV_S) / SEGMENT_WORDS + 1;
    localparam int unsigned MUL_W  = ADDR_W + 2;
    localparam int unsigned PROD_W = ADDR_W + MUL_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEGMENTS - 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_NO_MEMORY    = 2'd1,
        ST_BAD_ADDRESS  = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } status_t;

    typedef enum logic {
        FUNC_ALLOC   = 1'b0,
        FUNC_RELEASE = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_REL_DIV,
        S_REL_CHK,
        S_REL_RD,
        S_DONE
    } fsm_state_t;

    // Access to the use map: one write and one registered read per cycle
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic             wr_bit;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
    } map_req_t;

endpackage

@@ src/fspa_map.sv @@
// Segment use map: one busy bit per segment, one write port, one registered read port.
module fspa_map (
    input  logic              clk,
    input  fspa_pkg::map_req_t req,
    output logic              rd_bit
);
    import fspa_pkg::*;

    logic busy_mem [SEGMENTS];
    logic rd_bit_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            busy_mem[req.wr_idx] <= req.wr_bit;
        end
        if (req.rd_en)
        begin
            rd_bit_reg <= busy_mem[req.rd_idx];
        end
    end

    assign rd_bit = rd_bit_reg;

endmodule

@@ src/fixed_segment_pool_allocator.sv @@
// Top level of the fixed segment pool allocator: request sequencer, counters, result register.
//
// Hands out equal segments of SEGMENT_WORDS words from a pool of SEGMENTS, one busy bit per
// segment kept in a single-port-write, registered-read map. An allocate transfer (tuser 0)
// reads the map one bit per cycle from segment 0 upward and takes the first free one; its
// result comes later the higher the index of the segment taken, and an out-of-memory result
// comes once the bit of the last segment is checked, so the map read port sets the
// allocate time. A release transfer (tuser 1) takes these steps in order:
// one to turn the offset into an index by reciprocal multiply, one to check that the offset
// is a segment base and issue the map read, one to take the read bit and write back, and
// one to load the output register; an offset that is not a segment base skips the step that
// takes the read bit. A stalled result holds the sequencer in its last step.
// Items are handled one at a time; the next request is taken
// while the previous result still waits in the output register. After reset the map is
// cleared in a pass over every segment, during which no request is taken. Every result
// carries the in-use count after the request and the peak count since reset.
module fixed_segment_pool_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    // slave side
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fspa_pkg::IN_DATA_W-1:0]  s_tdata,   // [11:0] release_address, [15:12] zero
    input  logic                            s_tuser,   // [0] func
    // master side
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fspa_pkg::OUT_DATA_W-1:0] m_tdata    // [1:0] status, [13:2] segment_address,
                                                       // [18:14] in_use_count,
                                                       // [23:19] peak_in_use
);
    import fspa_pkg::*;

    fsm_state_t state_reg, state_next;

    // scan / clear index and read pipeline tracking
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             scan_live_reg, scan_live_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             chk_valid_reg, chk_valid_next;

    // release path
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] quot_reg, quot_next;

    // counters
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] peak_reg, peak_next;
    logic [CNT_W-1:0] count_inc;

    // pending result
    status_t           res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_seg_reg, res_seg_next;

    // output register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [PROD_W-1:0] div_prod;
    logic [BASE_W-1:0] base_prod;
    logic              base_ok;
    logic              out_free;
    logic              in_xfer;

    map_req_t map_req;
    logic     map_bit;

    fspa_map u_map (
        .clk    (clk),
        .req    (map_req),
        .rd_bit (map_bit)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign count_inc = count_reg + 1'b1;

    // offset -> candidate index, then verify it lands exactly on a segment base
    assign div_prod  = PROD_W'(addr_reg) * PROD_W'(MUL_W'(DIV_M));
    assign base_prod = BASE_W'(quot_reg) * BASE_W'(WORD_W'(SEGMENT_WORDS));
    assign base_ok   = (base_prod == BASE_W'(addr_reg)) && (32'(quot_reg) < SEGMENTS);

    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        scan_live_next  = scan_live_reg;
        chk_idx_next    = chk_idx_reg;
        chk_valid_next  = 1'b0;
        addr_next       = addr_reg;
        quot_next       = quot_reg;
        count_next      = count_reg;
        peak_next       = peak_reg;
        res_status_next = res_status_reg;
        res_seg_next    = res_seg_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        map_req         = '0;

        // output register drains independently of the sequencer
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                map_req.wr_en  = 1'b1;
                map_req.wr_idx = scan_idx_reg;
                map_req.wr_bit = 1'b0;
                scan_idx_next  = scan_idx_reg + 1'b1;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_xfer)
                begin
                    addr_next = s_tdata[ADDR_W-1:0];
                    if (func_t'(s_tuser) == FUNC_ALLOC)
                    begin
                        scan_idx_next  = '0;
                        scan_live_next = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_REL_DIV;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one map read a cycle, check the bit read last cycle
                map_req.rd_en  = scan_live_reg;
                map_req.rd_idx = scan_idx_reg;
                chk_valid_next = scan_live_reg;
                chk_idx_next   = scan_idx_reg;
                if (scan_idx_reg == LAST_IDX)
                begin
                    scan_live_next = 1'b0;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end

                if (chk_valid_reg && !map_bit)
                begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_idx  = chk_idx_reg;
                    map_req.wr_bit  = 1'b1;
                    count_next      = count_inc;
                    if (count_inc > peak_reg)
                    begin
                        peak_next = count_inc;
                    end
                    res_status_next = ST_OK;
                    res_seg_next    = ADDR_W'(32'(chk_idx_reg) * SEGMENT_WORDS);
                    scan_live_next  = 1'b0;
                    chk_valid_next  = 1'b0;
                    state_next      = S_DONE;
                end
                else if (chk_valid_reg && (chk_idx_reg == LAST_IDX))
                begin
                    res_status_next = ST_NO_MEMORY;
                    res_seg_next    = '0;
                    scan_live_next  = 1'b0;
                    chk_valid_next  = 1'b0;
                    state_next      = S_DONE;
                end
            end

            S_REL_DIV:
            begin
                quot_next  = ADDR_W'(div_prod >> DIV_S);
                state_next = S_REL_CHK;
            end

            S_REL_CHK:
            begin
                res_seg_next = '0;
                if (base_ok)
                begin
                    map_req.rd_en  = 1'b1;
                    map_req.rd_idx = quot_reg[IDX_W-1:0];
                    state_next     = S_REL_RD;
                end
                else
                begin
                    res_status_next = ST_BAD_ADDRESS;
                    state_next      = S_DONE;
                end
            end

            S_REL_RD:
            begin
                if (map_bit)
                begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_idx  = quot_reg[IDX_W-1:0];
                    map_req.wr_bit  = 1'b0;
                    count_next      = count_reg - 1'b1;
                    res_status_next = ST_OK;
                end
                else
                begin
                    res_status_next = ST_ALREADY_FREE;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // counters already hold the post-request values
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {CNT_OUT_W'(peak_reg), CNT_OUT_W'(count_reg),
                                     res_seg_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            scan_idx_reg  <= '0;
            scan_live_reg <= 1'b0;
            chk_valid_reg <= 1'b0;
            count_reg     <= '0;
            peak_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            scan_live_reg <= scan_live_next;
            chk_valid_reg <= chk_valid_next;
            count_reg     <= count_next;
            peak_reg      <= peak_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        addr_reg       <= addr_next;
        quot_reg       <= quot_next;
        res_status_reg <= res_status_next;
        res_seg_reg    <= res_seg_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule

@@ src/fspa_checker.sv @@
// Port-level checks for the fixed segment pool allocator and their bind.
module fspa_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fspa_pkg::OUT_DATA_W-1:0] m_tdata
);
    import fspa_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // in-use count never above the peak
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[18:14] <= m_tdata[23:19]))
        else $error("in-use count above peak");

    // only a successful request may carry a segment offset
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[13:2] == '0))
        else $error("offset on a failed request");

    // out of memory only with every segment in use
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == ST_NO_MEMORY) |->
            (m_tdata[18:14] == CNT_OUT_W'(SEGMENTS)))
        else $error("out of memory with a free segment");

endmodule

bind fixed_segment_pool_allocator fspa_checker u_fspa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
